// ===== hw/rtl/soa_pkg.sv =====
// Shared types and constants for the slab object allocator.
// No dependencies; imported by slab_object_allocator and soa_div.
package soa_pkg;

  // Field widths
  localparam int ADDR_W    = 48;
  localparam int PFN_W     = 36;
  localparam int OFF_W     = 12;
  localparam int OP_W      = 2;
  localparam int STATUS_W  = 3;
  localparam int INUSE_W   = 14;
  localparam int SLABS_W   = 5;
  localparam int TOTAL_W   = 32;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 36;
  localparam int SIZE_W    = 13;

  // Geometry
  localparam int PAGE_BYTES    = 4096;
  localparam int HEADER_BYTES  = 48;
  localparam int DEFAULT_ALIGN = 16;
  localparam int MIN_ALIGN     = 8;
  localparam int GEO_W         = 14;  // aligned sizes up to 8192
  localparam int DIV_W         = 12;  // dividends stay below one page
  localparam int DIV_CNT_W     = 4;

  // Pool
  localparam int POOL_PAGES = 16;
  localparam int PG_W       = 4;
  localparam int LINK_W     = PG_W + 1;
  localparam int MAX_SLOTS  = 512;
  localparam int SLOT_W     = 9;
  localparam int CNT_W      = 10;
  localparam int RAM_DEPTH  = POOL_PAGES * MAX_SLOTS;
  localparam int RAM_AW     = PG_W + SLOT_W;

  localparam logic [LINK_W-1:0] NIL_PAGE = LINK_W'(POOL_PAGES);
  localparam logic [SIZE_W-1:0] OBJ_SIZE_RST = SIZE_W'(64);

  // Operations
  localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
  localparam logic [OP_W-1:0] OP_FREE    = 2'd1;
  localparam logic [OP_W-1:0] OP_DESTROY = 2'd2;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NO_PAGES  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_LIVE  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_OVER_FREE = 3'd3;
  localparam logic [STATUS_W-1:0] ST_DOUBLE    = 3'd4;
  localparam logic [STATUS_W-1:0] ST_CONFIG    = 3'd5;
  localparam logic [STATUS_W-1:0] ST_NOT_START = 3'd6;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_POOL_BASE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OBJ_SIZE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ALIGN     = 2'd2;

  typedef struct packed {
    logic              start;
    logic [DIV_W-1:0]  dividend;
    logic [GEO_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIV_W-1:0]  quot;
    logic [DIV_W-1:0]  rem;
  } div_rsp_t;

endpackage

// ===== hw/rtl/slab_object_allocator.sv =====
// Slab object allocator: sequencer, page lists and per-page free lists.
// Depends on soa_pkg, soa_div (shared divider) and soa_ram (slot link store).
//
// One request is taken at a time; in_stall_o stays high until its result is
// loaded into the output register. Every allocate or free first runs the
// shared divider to size the page. An allocate from a partial page then
// pops a slot (S_POP, S_POP2) and may move the page to the full list (S_REM,
// S_PUSH); growing a new page first carves each slot into the link RAM (up to
// 506) and then links the page. A free runs the divider a second time to find
// the slot, then walks the page free list for double-free detection (one link
// RAM read per node), then updates the lists. Destroy and unknown operations
// go straight to S_DONE. The slot link RAM is not cleared after reset; pages
// are carved before use.
module slab_object_allocator import soa_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [OP_W-1:0]      operation_i,
  input  logic [ADDR_W-1:0]    object_address_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [ADDR_W-1:0]    result_address_o,
  output logic [STATUS_W-1:0]  status_o,
  output logic [INUSE_W-1:0]   objects_in_use_o,
  output logic [SLABS_W-1:0]   slabs_in_use_o,
  output logic [TOTAL_W-1:0]   alloc_count_o,
  output logic [TOTAL_W-1:0]   free_count_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_GEO   = 4'd1;
  localparam logic [3:0] S_FCHK  = 4'd2;
  localparam logic [3:0] S_CARVE = 4'd3;
  localparam logic [3:0] S_PUSH  = 4'd4;
  localparam logic [3:0] S_POP   = 4'd5;
  localparam logic [3:0] S_POP2  = 4'd6;
  localparam logic [3:0] S_FDIV  = 4'd7;
  localparam logic [3:0] S_WALK  = 4'd8;
  localparam logic [3:0] S_WALK2 = 4'd9;
  localparam logic [3:0] S_FUPD  = 4'd10;
  localparam logic [3:0] S_REM   = 4'd11;
  localparam logic [3:0] S_DONE  = 4'd12;

  // configuration
  logic [PFN_W-1:0]  base_q;
  logic [SIZE_W-1:0] obj_q, align_q;

  // control state
  logic [3:0]            state_q;
  logic                  out_valid_q;
  logic [POOL_PAGES-1:0] live_q, full_q;
  logic [CNT_W-1:0]      count_q [POOL_PAGES];
  logic [LINK_W-1:0]     partial_head_q, full_head_q;
  logic [INUSE_W-1:0]    in_use_q;
  logic [SLABS_W-1:0]    slab_q;
  logic [TOTAL_W-1:0]    allocs_q, frees_q;
  logic                  mv_q, push_full_q, carving_q, rel_pend_q;

  // payload
  logic [OP_W-1:0]          op_q;
  logic [ADDR_W-1:0]        oaddr_q;
  logic [PG_W-1:0]          pg_q;
  logic [SLOT_W-1:0]        slot_q, node_q, cidx_q;
  logic [CNT_W-1:0]         k_q, per_q;
  logic                     geo_ok_q;
  logic [SLOT_W+GEO_W-1:0]  prod_q;
  logic [ADDR_W-1:0]        res_addr_q;
  logic [STATUS_W-1:0]      status_q;
  logic [SLOT_W-1:0]        free_head_q [POOL_PAGES];
  logic [LINK_W-1:0]        next_q [POOL_PAGES];
  logic [LINK_W-1:0]        prev_q [POOL_PAGES];
  logic [ADDR_W-1:0]        out_addr_q;
  logic [STATUS_W-1:0]      out_status_q;
  logic [INUSE_W-1:0]       out_in_use_q;
  logic [SLABS_W-1:0]       out_slabs_q;
  logic [TOTAL_W-1:0]       out_allocs_q, out_frees_q;

  // ---------------- configuration port ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q  <= '0;
      obj_q   <= OBJ_SIZE_RST;
      align_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_POOL_BASE: base_q  <= cfg_wdata_i;
        CFG_OBJ_SIZE:  obj_q   <= cfg_wdata_i[SIZE_W-1:0];
        CFG_ALIGN:     align_q <= cfg_wdata_i[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- geometry ----------------
  logic [SIZE_W-1:0] align_eff;
  logic [GEO_W-1:0]  pow, pmask, first, obj_eff, slotsz;
  logic              first_ok, obj_ok;

  assign align_eff = (align_q == '0) ? SIZE_W'(DEFAULT_ALIGN) : align_q;

  always_comb begin
    pow = GEO_W'(MIN_ALIGN);
    for (int i = 3; i < 13; i++) begin
      if ({1'b0, align_eff} > (GEO_W'(1) << i)) begin
        pow = GEO_W'(1) << (i + 1);
      end
    end
  end

  assign pmask    = pow - 1'b1;
  assign first    = (GEO_W'(HEADER_BYTES) + pmask) & ~pmask;
  assign obj_eff  = (obj_q < SIZE_W'(MIN_ALIGN)) ? GEO_W'(MIN_ALIGN) : {1'b0, obj_q};
  assign slotsz   = (obj_eff + pmask) & ~pmask;
  assign first_ok = first < GEO_W'(PAGE_BYTES);
  assign obj_ok   = obj_q != '0;

  // ---------------- shared divider ----------------
  div_req_t div_req;
  div_rsp_t div_rsp;

  logic [OFF_W-1:0] off;
  logic [PFN_W-1:0] pfn, pfn_diff;
  logic             in_pool;
  logic [CNT_W-1:0] cur_count, cnt_dec, cnt_inc, q_cap;
  logic [SLOT_W-1:0] cur_head;
  logic [LINK_W-1:0] cur_next, cur_prev, push_head;
  logic             cur_live, cur_full, fchk_go, geo_ok_now, carve_last, page_drop;
  logic             free_found;
  logic [PG_W-1:0]  free_pg;

  assign off       = oaddr_q[OFF_W-1:0];
  assign pfn       = oaddr_q[ADDR_W-1:OFF_W];
  assign pfn_diff  = pfn - base_q;
  assign in_pool   = (pfn >= base_q) && (pfn_diff[PFN_W-1:PG_W] == '0);

  assign cur_count = count_q[pg_q];
  assign cur_head  = free_head_q[pg_q];
  assign cur_next  = next_q[pg_q];
  assign cur_prev  = prev_q[pg_q];
  assign cur_live  = live_q[pg_q];
  assign cur_full  = full_q[pg_q];
  assign cnt_dec   = (cur_count != '0) ? cur_count - 1'b1 : cur_count;
  assign cnt_inc   = cur_count + 1'b1;
  assign page_drop = cnt_inc >= per_q;
  assign push_head = push_full_q ? full_head_q : partial_head_q;

  assign q_cap      = (div_rsp.quot > DIV_W'(MAX_SLOTS)) ? CNT_W'(MAX_SLOTS)
                                                         : div_rsp.quot[CNT_W-1:0];
  assign geo_ok_now = obj_ok && first_ok && (q_cap != '0);
  assign carve_last = ({1'b0, cidx_q} == per_q - 1'b1);
  assign fchk_go    = cur_live && geo_ok_q && (cur_count < per_q) &&
                      ({2'b0, off} >= first);

  // lowest page not yet owned
  always_comb begin
    free_found = 1'b0;
    free_pg    = '0;
    for (int i = POOL_PAGES - 1; i >= 0; i--) begin
      if (!live_q[i]) begin
        free_found = 1'b1;
        free_pg    = PG_W'(i);
      end
    end
  end

  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = DIV_W'(GEO_W'(PAGE_BYTES) - first);
    div_req.divisor  = slotsz;
    if (state_q == S_IDLE && in_valid_i &&
        (operation_i == OP_ALLOC || operation_i == OP_FREE)) begin
      div_req.start = 1'b1;
    end else if (state_q == S_FCHK && fchk_go) begin
      div_req.start    = 1'b1;
      div_req.dividend = off - first[OFF_W-1:0];
    end
  end

  soa_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // ---------------- slot link RAM ----------------
  logic              ram_we, ram_re;
  logic [RAM_AW-1:0] ram_waddr, ram_raddr;
  logic [SLOT_W-1:0] ram_wdata, ram_rdata;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = {pg_q, cidx_q};
    ram_wdata = (cidx_q == '0) ? '0 : cidx_q - 1'b1;
    ram_re    = 1'b0;
    ram_raddr = {pg_q, node_q};
    unique case (state_q)
      S_CARVE: ram_we = 1'b1;
      S_FUPD: begin
        ram_we    = 1'b1;
        ram_waddr = {pg_q, slot_q};
        ram_wdata = cur_head;
      end
      S_POP: begin
        ram_re    = 1'b1;
        ram_raddr = {pg_q, cur_head};
      end
      S_WALK: ram_re = 1'b1;
      default: ;
    endcase
  end

  soa_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (RAM_DEPTH)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  logic out_free;
  assign out_free = !out_valid_q || !out_stall_i;

  // ---------------- sequencer and control state ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      out_valid_q    <= 1'b0;
      live_q         <= '0;
      full_q         <= '0;
      for (int i = 0; i < POOL_PAGES; i++) count_q[i] <= '0;
      partial_head_q <= NIL_PAGE;
      full_head_q    <= NIL_PAGE;
      in_use_q       <= '0;
      slab_q         <= '0;
      allocs_q       <= '0;
      frees_q        <= '0;
      mv_q           <= 1'b0;
      push_full_q    <= 1'b0;
      carving_q      <= 1'b0;
      rel_pend_q     <= 1'b0;
    end else begin
      // S_DONE owns the valid flag in its own cycle
      if (out_valid_q && !out_stall_i && state_q != S_DONE) out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: if (in_valid_i) begin
          unique case (operation_i)
            OP_ALLOC, OP_FREE: state_q <= S_GEO;
            OP_DESTROY: begin
              live_q         <= '0;
              full_q         <= '0;
              partial_head_q <= NIL_PAGE;
              full_head_q    <= NIL_PAGE;
              in_use_q       <= '0;
              slab_q         <= '0;
              state_q        <= S_DONE;
            end
            default: state_q <= S_DONE;
          endcase
        end
        S_GEO: if (div_rsp.done) begin
          if (op_q == OP_ALLOC) begin
            priority if (!geo_ok_now)                state_q <= S_DONE;
            else if (partial_head_q != NIL_PAGE)     state_q <= S_POP;
            else if (!free_found)                    state_q <= S_DONE;
            else                                     state_q <= S_CARVE;
          end else begin
            state_q <= (oaddr_q == '0 || !in_pool) ? S_DONE : S_FCHK;
          end
        end
        S_FCHK: state_q <= fchk_go ? S_FDIV : S_DONE;
        S_CARVE: if (carve_last) begin
          live_q[pg_q]  <= 1'b1;
          full_q[pg_q]  <= 1'b0;
          count_q[pg_q] <= per_q;
          slab_q        <= slab_q + 1'b1;
          push_full_q   <= 1'b0;
          carving_q     <= 1'b1;
          rel_pend_q    <= 1'b0;
          state_q       <= S_PUSH;
        end
        S_PUSH: begin
          full_q[pg_q] <= push_full_q;
          if (push_full_q) full_head_q <= {1'b0, pg_q};
          else             partial_head_q <= {1'b0, pg_q};
          priority if (carving_q) begin
            carving_q <= 1'b0;
            state_q   <= S_POP;
          end else if (rel_pend_q) begin
            rel_pend_q <= 1'b0;
            mv_q       <= 1'b0;
            state_q    <= S_REM;
          end else begin
            state_q <= S_DONE;
          end
        end
        S_POP: state_q <= S_POP2;
        S_POP2: begin
          count_q[pg_q] <= cnt_dec;
          in_use_q      <= in_use_q + 1'b1;
          allocs_q      <= allocs_q + 1'b1;
          if (cnt_dec == '0) begin
            mv_q        <= 1'b1;
            push_full_q <= 1'b1;
            rel_pend_q  <= 1'b0;
            state_q     <= S_REM;
          end else begin
            state_q <= S_DONE;
          end
        end
        S_FDIV: if (div_rsp.done) begin
          state_q <= (div_rsp.rem != '0 || div_rsp.quot >= {2'b0, per_q}) ? S_DONE
                                                                          : S_WALK;
        end
        S_WALK: begin
          priority if (k_q == cur_count) state_q <= S_FUPD;
          else if (node_q == slot_q)     state_q <= S_DONE;
          else                           state_q <= S_WALK2;
        end
        S_WALK2: state_q <= S_WALK;
        S_FUPD: begin
          count_q[pg_q] <= cnt_inc;
          in_use_q      <= (in_use_q != '0) ? in_use_q - 1'b1 : in_use_q;
          frees_q       <= frees_q + 1'b1;
          priority if (cur_full) begin
            mv_q        <= 1'b1;
            push_full_q <= 1'b0;
            rel_pend_q  <= page_drop;
            state_q     <= S_REM;
          end else if (page_drop) begin
            mv_q    <= 1'b0;
            state_q <= S_REM;
          end else begin
            state_q <= S_DONE;
          end
        end
        S_REM: begin
          if (cur_prev == NIL_PAGE) begin
            if (cur_full) full_head_q <= cur_next;
            else          partial_head_q <= cur_next;
          end
          if (mv_q) begin
            state_q <= S_PUSH;
          end else begin
            live_q[pg_q] <= 1'b0;
            slab_q       <= (slab_q != '0) ? slab_q - 1'b1 : slab_q;
            state_q      <= S_DONE;
          end
        end
        S_DONE: if (out_free) begin
          out_valid_q <= 1'b1;
          state_q     <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // ---------------- datapath ----------------
  logic [PFN_W-1:0]  page_pfn;
  logic [ADDR_W-1:0] slot_addr;

  assign page_pfn  = base_q + PFN_W'(pg_q);
  assign slot_addr = {page_pfn, OFF_W'(0)} + ADDR_W'(first) + ADDR_W'(prod_q);

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: if (in_valid_i) begin
        op_q     <= operation_i;
        oaddr_q  <= object_address_i;
        status_q <= ST_OK;
      end
      S_GEO: if (div_rsp.done) begin
        per_q    <= q_cap;
        geo_ok_q <= geo_ok_now;
        cidx_q   <= '0;
        if (op_q == OP_ALLOC) begin
          priority if (!geo_ok_now)            status_q <= ST_CONFIG;
          else if (partial_head_q != NIL_PAGE) pg_q <= partial_head_q[PG_W-1:0];
          else if (!free_found)                status_q <= ST_NO_PAGES;
          else                                 pg_q <= free_pg;
        end else if (oaddr_q != '0) begin
          if (!in_pool) status_q <= ST_NOT_LIVE;
          else          pg_q <= pfn_diff[PG_W-1:0];
        end
      end
      S_FCHK: begin
        priority if (!cur_live)          status_q <= ST_NOT_LIVE;
        else if (!geo_ok_q)              status_q <= ST_CONFIG;
        else if (cur_count >= per_q)     status_q <= ST_OVER_FREE;
        else if ({2'b0, off} < first)    status_q <= ST_NOT_START;
        else                             status_q <= ST_OK;
      end
      S_CARVE: begin
        cidx_q <= cidx_q + 1'b1;
        if (carve_last) free_head_q[pg_q] <= SLOT_W'(per_q - 1'b1);
      end
      S_PUSH: begin
        prev_q[pg_q] <= NIL_PAGE;
        next_q[pg_q] <= push_head;
        if (push_head != NIL_PAGE) prev_q[push_head[PG_W-1:0]] <= {1'b0, pg_q};
      end
      S_POP: begin
        slot_q <= cur_head;
        prod_q <= cur_head * slotsz;
      end
      S_POP2: begin
        free_head_q[pg_q] <= ram_rdata;
        res_addr_q        <= slot_addr;
      end
      S_FDIV: if (div_rsp.done) begin
        if (div_rsp.rem != '0 || div_rsp.quot >= {2'b0, per_q}) status_q <= ST_NOT_START;
        slot_q <= div_rsp.quot[SLOT_W-1:0];
        node_q <= cur_head;
        k_q    <= '0;
      end
      S_WALK: if (k_q != cur_count && node_q == slot_q) status_q <= ST_DOUBLE;
      S_WALK2: begin
        node_q <= ram_rdata;
        k_q    <= k_q + 1'b1;
      end
      S_FUPD: free_head_q[pg_q] <= slot_q;
      S_REM: begin
        if (cur_prev != NIL_PAGE) next_q[cur_prev[PG_W-1:0]] <= cur_next;
        if (cur_next != NIL_PAGE) prev_q[cur_next[PG_W-1:0]] <= cur_prev;
      end
      S_DONE: if (out_free) begin
        out_addr_q   <= (op_q == OP_ALLOC && status_q == ST_OK) ? res_addr_q : '0;
        out_status_q <= status_q;
        out_in_use_q <= in_use_q;
        out_slabs_q  <= slab_q;
        out_allocs_q <= allocs_q;
        out_frees_q  <= frees_q;
      end
      default: ;
    endcase
  end

  assign in_stall_o       = state_q != S_IDLE;
  assign out_valid_o      = out_valid_q;
  assign result_address_o = out_addr_q;
  assign status_o         = out_status_q;
  assign objects_in_use_o = out_in_use_q;
  assign slabs_in_use_o   = out_slabs_q;
  assign alloc_count_o    = out_allocs_q;
  assign free_count_o     = out_frees_q;

`ifndef SYNTHESIS
  // slab count tracks the owned pages exactly
  a_slab_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    slab_q == SLABS_W'($countones(live_q)))
    else $error("slab count out of step with live pages");

  // a page on the full list is always owned
  a_full_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (full_q & ~live_q) == '0)
    else $error("full-list page not live");

  // head of the partial list is a live page not marked full
  a_partial_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (partial_head_q != NIL_PAGE) |->
      (live_q[partial_head_q[PG_W-1:0]] && !full_q[partial_head_q[PG_W-1:0]]))
    else $error("partial head not a live partial page");
`endif

endmodule

// ===== hw/rtl/soa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module soa_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 8192
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/soa_div.sv =====
// Restoring divider, one quotient bit per cycle, shared by geometry and free decode.
// Depends on soa_pkg for widths and the request/response structs.
module soa_div import soa_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic                 busy_q, done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [DIV_W-1:0]     quo_q, rem_q;
  logic [GEO_W-1:0]     dvs_q;
  logic [DIV_W:0]       trial, diff;
  logic                 fits;

  assign trial = {rem_q, quo_q[DIV_W-1]};
  assign fits  = {1'b0, trial} >= dvs_q;
  assign diff  = trial - dvs_q[DIV_W:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= DIV_CNT_W'(DIV_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == DIV_CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quo_q <= req_i.dividend;
      rem_q <= '0;
      dvs_q <= req_i.divisor;
    end else if (busy_q) begin
      rem_q <= fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
      quo_q <= {quo_q[DIV_W-2:0], fits};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quo_q;
  assign rsp_o.rem  = rem_q;

endmodule
